[design/mavg_pkg.sv]
package mavg_pkg;

  localparam int MaxWindow  = 64;
  localparam int SampleBits = 16;
  localparam int WinBits    = 7;
  localparam int SlotBits   = $clog2(MaxWindow);
  localparam int SumBits    = 22;
  localparam int DivCntBits = $clog2(SumBits);

  localparam logic [WinBits-1:0] WinReset = WinBits'(8);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SUM  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } mavg_state_t;

endpackage

[design/moving_average_filter.sv]
// Boxcar moving average of signed Q8.8 samples.
// Input channel: in_valid/in_stall carry in_sample_value and in_series_start.
// An item with in_series_start set restarts the fill with that sample.
// Result channel: out_valid/out_stall carry out_window_mean, the sum of the
// last window_length samples divided by window_length, truncated toward zero.
// No result appears until the window has filled; after that every item gives one.
// cfg_wr_en/cfg_wr_data write window_length (0 acts as 1, above 64 as 64);
// a write restarts the fill. Write only while the block is idle.
// Sequence: an item is taken, the running sum is updated in the next cycle,
// then a restoring divider produces one quotient bit per cycle, and ST_DONE
// loads the output register and raises out_valid. No new item is taken until
// its result has moved into the output register.
// An item that gives no result frees the block once the running sum is updated.
// The result waits in the output register while out_stall is high; the next
// item is accepted meanwhile, and its result waits in the divider until the
// output register is free.
// Reset (rst_n low, synchronous) clears sum and fill, sets window_length to 8.
module moving_average_filter import mavg_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [SampleBits-1:0] in_sample_value,
  input  logic                         in_series_start,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [SampleBits-1:0] out_window_mean,
  input  logic                         cfg_wr_en,
  input  logic [WinBits-1:0]           cfg_wr_data
);

  mavg_state_t                  state_r;
  logic [WinBits-1:0]           win_r;
  logic [WinBits-1:0]           fill_r;
  logic [SlotBits-1:0]          slot_r;
  logic signed [SumBits-1:0]    sum_r;
  logic                         sub_r;
  logic                         emit_r;
  logic [DivCntBits-1:0]        div_cnt_r;
  logic [WinBits-1:0]           rem_r;
  logic [SumBits-1:0]           quo_r;
  logic                         neg_r;
  logic                         out_valid_r;
  logic signed [SampleBits-1:0] out_mean_r;
  logic signed [SampleBits-1:0] x_r;
  logic signed [SampleBits-1:0] old_r;

  logic signed [SampleBits-1:0] ring [MaxWindow];

  logic [WinBits-1:0]        w_eff;
  logic                      accept;
  logic [WinBits-1:0]        cnt_base;
  logic [SlotBits-1:0]       old_addr;
  logic signed [SumBits-1:0] sum_nxt;
  logic [SumBits-1:0]        mag_nxt;
  logic [WinBits:0]          shifted;
  logic                      ge;
  logic [WinBits:0]          diff;
  logic                      out_free;
  logic [SampleBits-1:0]     mean_nxt;

  always_comb begin
    if (win_r == '0) begin
      w_eff = WinBits'(1);
    end else if (win_r > WinBits'(MaxWindow)) begin
      w_eff = WinBits'(MaxWindow);
    end else begin
      w_eff = win_r;
    end
  end

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign cnt_base = in_series_start ? '0 : fill_r;
  // window of MaxWindow wraps onto the slot being written: read-before-write
  assign old_addr = slot_r - w_eff[SlotBits-1:0];

  assign sum_nxt = sum_r + SumBits'(x_r) - (sub_r ? SumBits'(old_r) : '0);
  assign mag_nxt = sum_nxt[SumBits-1] ? SumBits'(-sum_nxt) : SumBits'(sum_nxt);

  // one restoring step: shift in next dividend bit, subtract if it fits
  assign shifted = {rem_r, quo_r[SumBits-1]};
  assign ge      = (shifted >= {1'b0, w_eff});
  assign diff    = shifted - {1'b0, w_eff};

  assign out_free = !out_valid_r || !out_stall;
  assign mean_nxt = neg_r ? SampleBits'(-quo_r[SampleBits-1:0]) : quo_r[SampleBits-1:0];

  always_ff @(posedge clk) begin
    if (accept) begin
      old_r        <= ring[old_addr];
      ring[slot_r] <= in_sample_value;
      x_r          <= in_sample_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      win_r       <= WinReset;
      fill_r      <= '0;
      slot_r      <= '0;
      sum_r       <= '0;
      sub_r       <= 1'b0;
      emit_r      <= 1'b0;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (cfg_wr_en) begin
            win_r  <= cfg_wr_data;
            sum_r  <= '0;
            fill_r <= '0;
          end else if (accept) begin
            if (in_series_start) begin
              sum_r <= '0;
            end
            sub_r  <= (cnt_base >= w_eff);
            fill_r <= (cnt_base < w_eff) ? cnt_base + WinBits'(1) : cnt_base;
            emit_r <= (cnt_base + WinBits'(1) >= w_eff);
            slot_r <= slot_r + SlotBits'(1);
            state_r <= ST_SUM;
          end
        end
        ST_SUM: begin
          sum_r     <= sum_nxt;
          div_cnt_r <= '0;
          state_r   <= emit_r ? ST_DIV : ST_IDLE;
        end
        ST_DIV: begin
          div_cnt_r <= div_cnt_r + DivCntBits'(1);
          if (div_cnt_r == DivCntBits'(SumBits - 1)) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_SUM: begin
        quo_r <= mag_nxt;
        rem_r <= '0;
        neg_r <= sum_nxt[SumBits-1];
      end
      ST_DIV: begin
        rem_r <= ge ? diff[WinBits-1:0] : shifted[WinBits-1:0];
        quo_r <= {quo_r[SumBits-2:0], ge};
      end
      ST_DONE: begin
        if (out_free) begin
          out_mean_r <= mean_nxt;
        end
      end
      default: ;
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_window_mean = out_mean_r;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= WinBits'(MaxWindow))
    else $error("fill count exceeds window limit");

  a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (div_cnt_r < DivCntBits'(SumBits)))
    else $error("divider step count out of range");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |-> (rem_r < w_eff))
    else $error("divider remainder not below window");

  a_quo_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |-> (quo_r <= SumBits'(1 << (SampleBits - 1))))
    else $error("mean magnitude out of sample range");

  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_free) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("finished item not moved to output register");
`endif

endmodule
